// ===== hdl/frf_pkg.sv =====
// Package for the FIR row filter: payload structs, codes and default sizes.
// Used by every module of the filter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package frf_pkg;

  localparam int unsigned MAX_TAPS_DEF = 512;
  localparam int unsigned ROW_MAX_DEF  = 4096;

  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned TAP_INDEX_W = 9;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned RESULT_W    = 41;
  localparam int unsigned POSITION_W  = 12;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_NEG  = 1'd1;

  typedef enum logic [0:0] {
    OP_LOAD_TAP    = 1'b0,
    OP_PUSH_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                       operation;
    logic [TAP_INDEX_W-1:0]    tap_index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_start;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic [POSITION_W-1:0]      position;
  } out_item_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_INSERT,
    RING_DOWN,
    RING_UP
  } ring_mode_e;

  typedef struct packed {
    logic clear;
    logic issue;
    logic tap_we;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_RESTORE,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/frf_cell.sv =====
// One cell of the sample row: holds a single sample and takes its neighbour's value.
// Depends on frf_pkg for the ring mode and sample width.
`timescale 1ns / 1ps
`default_nettype none

module frf_cell import frf_pkg::*; (
  input  logic                      clk_i,
  input  ring_mode_e                mode_i,
  input  logic signed [VALUE_W-1:0] from_lo_i,
  input  logic signed [VALUE_W-1:0] from_hi_i,
  output logic signed [VALUE_W-1:0] sample_o
);

  logic signed [VALUE_W-1:0] sample_q, sample_d;

  always_comb begin
    case (mode_i) inside
      RING_INSERT, RING_UP: sample_d = from_lo_i;
      RING_DOWN:            sample_d = from_hi_i;
      default:              sample_d = sample_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

// ===== hdl/frf_chain.sv =====
// Row of sample cells closed into a ring; cell 0 is the newest sample and the read point.
// Depends on frf_pkg and frf_cell.
`timescale 1ns / 1ps
`default_nettype none

module frf_chain import frf_pkg::*; #(
  parameter int unsigned NumCells = MAX_TAPS_DEF
) (
  input  logic                      clk_i,
  input  ring_mode_e                mode_i,
  input  logic signed [VALUE_W-1:0] sample_i,
  output logic signed [VALUE_W-1:0] head_o
);

  logic signed [VALUE_W-1:0] cell_s [NumCells];
  logic signed [VALUE_W-1:0] lo_s   [NumCells];
  logic signed [VALUE_W-1:0] hi_s   [NumCells];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lo_s[i] = (mode_i == RING_INSERT) ? sample_i : cell_s[NumCells-1];
    end else begin : g_rest
      assign lo_s[i] = cell_s[i-1];
    end
    assign hi_s[i] = cell_s[(i+1) % NumCells];

    frf_cell u_cell (
      .clk_i     (clk_i),
      .mode_i    (mode_i),
      .from_lo_i (lo_s[i]),
      .from_hi_i (hi_s[i]),
      .sample_o  (cell_s[i])
    );
  end

  assign head_o = cell_s[0];

endmodule

`default_nettype wire

// ===== hdl/frf_mac.sv =====
// Tap memory and the multiply-accumulate pipeline with saturation and rectification.
// Depends on frf_pkg for the control struct and field widths.
`timescale 1ns / 1ps
`default_nettype none

module frf_mac import frf_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic [$clog2(MaxTaps)-1:0] tap_waddr_i,
  input  logic signed [VALUE_W-1:0]  tap_wdata_i,
  input  logic [$clog2(MaxTaps)-1:0] tap_raddr_i,
  input  logic signed [VALUE_W-1:0]  sample_i,
  input  logic                       zero_neg_i,
  output logic signed [RESULT_W-1:0] result_o,
  output logic                       busy_o
);

  localparam int unsigned AccW = PROD_W + $clog2(MaxTaps);
  localparam int unsigned SatW = (AccW > RESULT_W) ? AccW : RESULT_W;
  localparam logic signed [SatW-1:0] ResMax = SatW'({1'b0, {(RESULT_W-1){1'b1}}});
  localparam logic signed [SatW-1:0] ResMin = ~ResMax;

  logic signed [VALUE_W-1:0] tap_mem [MaxTaps];

  logic signed [VALUE_W-1:0] tap_rd_q, sample_q;
  logic signed [PROD_W-1:0]  product_q;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic                      v1_q, v2_q;
  logic signed [SatW-1:0]    acc_ext, acc_sat;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_we) begin
      tap_mem[tap_waddr_i] <= tap_wdata_i;
    end
    if (ctrl_i.issue) begin
      tap_rd_q <= tap_mem[tap_raddr_i];
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + AccW'(product_q);
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= tap_rd_q * sample_q;
    acc_q     <= acc_d;
  end

  always_comb begin
    acc_ext = SatW'(acc_q);
    if (acc_ext > ResMax) begin
      acc_sat = ResMax;
    end else if (acc_ext < ResMin) begin
      acc_sat = ResMin;
    end else begin
      acc_sat = acc_ext;
    end
    if (zero_neg_i && acc_sat[SatW-1]) begin
      acc_sat = '0;
    end
  end

  assign result_o = RESULT_W'(acc_sat);
  assign busy_o   = v1_q | v2_q;

endmodule

`default_nettype wire

// ===== hdl/fir_row_filter_with_rectify_top.sv =====
// Top level of the FIR row filter: configuration, row counting and the sequencer.
// Depends on frf_pkg, frf_chain (with frf_cell) and frf_mac.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_stall_o  in_item_i  (in_item_t)
//   out      out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg      cfg_we_i                 cfg_index_i, cfg_data_i
//
// A tap load or a sample that gives no result is taken while idle and stalls nothing.
// A sample that gives a result stalls the input while the sample row turns past its
// single read point at cell 0 once per tap in use and then turns back, and until the
// accumulation has drained and the output register is free to take the result.
// A waiting result in the output register does not block the next request.
// Reset clears the control state and configuration; the sample cells and tap memory are not reset.
`timescale 1ns / 1ps
`default_nettype none

module fir_row_filter_with_rectify_top import frf_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS_DEF,
  parameter int unsigned RowMax  = ROW_MAX_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned TapAw   = $clog2(MaxTaps);
  localparam int unsigned TapCntW = $clog2(MaxTaps + 1);
  localparam int unsigned RowCntW = $clog2(RowMax + 1);

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] tap_count_q;
  logic                  zero_neg_q;
  logic [RowCntW-1:0]    row_cnt_q, row_base, row_new;
  logic [TapAw-1:0]      cnt_q, cnt_d;
  logic [TapCntW-1:0]    t_eff;
  logic [TapAw-1:0]      t_m1;

  logic in_acc, is_push, row_drop, result_due, tap_ok, out_free, out_load;

  ring_mode_e                 ring_mode;
  mac_ctrl_t                  mac_ctrl;
  logic signed [VALUE_W-1:0]  head_sample;
  logic signed [RESULT_W-1:0] mac_result;
  logic                       mac_busy;

  logic      out_valid_q;
  out_item_t out_q;

  always_comb begin
    if (tap_count_q == '0) begin
      t_eff = TapCntW'(1);
    end else if (32'(tap_count_q) > MaxTaps) begin
      t_eff = TapCntW'(MaxTaps);
    end else begin
      t_eff = TapCntW'(tap_count_q);
    end
  end

  assign t_m1 = TapAw'(t_eff - 1'b1);

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign is_push    = (in_item_i.operation == OP_PUSH_SAMPLE);
  assign tap_ok     = (32'(in_item_i.tap_index) < MaxTaps);
  assign row_base   = in_item_i.row_start ? '0 : row_cnt_q;
  assign row_drop   = (32'(row_base) >= RowMax);
  assign row_new    = row_base + 1'b1;
  assign result_due = !row_drop && (32'(row_new) >= 32'(t_eff));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= CFG_DATA_W'(1);
      zero_neg_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TAP_COUNT: tap_count_q <= cfg_data_i;
        CFG_ZERO_NEG:  zero_neg_q  <= cfg_data_i[0];
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_push && result_due) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_q == t_m1) begin
          state_d = (t_m1 == '0) ? ST_FINISH : ST_RESTORE;
        end
      end
      ST_RESTORE: begin
        if (cnt_q == TapAw'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!mac_busy && out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ring_mode  = RING_HOLD;
    mac_ctrl   = '0;
    out_load   = 1'b0;
    cnt_d      = cnt_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          if (is_push) begin
            if (!row_drop) begin
              ring_mode = RING_INSERT;
            end
            mac_ctrl.clear = result_due;
          end else begin
            mac_ctrl.tap_we = tap_ok;
          end
        end
      end
      ST_MAC: begin
        mac_ctrl.issue = 1'b1;
        if (cnt_q != t_m1) begin
          ring_mode = RING_DOWN;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      ST_RESTORE: begin
        ring_mode = RING_UP;
        cnt_d     = cnt_q - 1'b1;
      end
      ST_FINISH: begin
        out_load = !mac_busy && out_free;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_acc && is_push && !row_drop) begin
        row_cnt_q <= row_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.result   <= mac_result;
      out_q.position <= POSITION_W'(32'(row_cnt_q) - 32'(t_eff));
    end
  end

  frf_chain #(
    .NumCells (MaxTaps)
  ) u_chain (
    .clk_i    (clk_i),
    .mode_i   (ring_mode),
    .sample_i (in_item_i.value),
    .head_o   (head_sample)
  );

  frf_mac #(
    .MaxTaps (MaxTaps)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .tap_waddr_i (TapAw'(in_item_i.tap_index)),
    .tap_wdata_i (in_item_i.value),
    .tap_raddr_i (t_m1 - cnt_q),
    .sample_i    (head_sample),
    .zero_neg_i  (zero_neg_q),
    .result_o    (mac_result),
    .busy_o      (mac_busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_mac_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (cnt_q <= t_m1))
    else $error("Tap counter ran past the taps in use.");

  a_restore_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESTORE) |-> (cnt_q != '0))
    else $error("Ring restore entered with nothing to undo.");

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH && !mac_busy))
    else $error("Result presented without a finished accumulation.");

  a_busy_after_result_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_push && result_due) |=> (in_stall_o && mac_ctrl.issue))
    else $error("Sample that completes a window did not start the accumulation.");
`endif

endmodule

`default_nettype wire

// ===== test/fir_row_filter_check.sv =====
// Checker for the FIR row filter: watches the request, result and register ports,
// predicts every filter sum and compares it with what the block delivers.
// Depends on frf_pkg for the payload types, register indexes and default sizes.
`timescale 1ns / 1ps

module fir_row_filter_check import frf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  out_item_t              out_item_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fails_o,
  output int                     pending_o
);

  localparam longint SumMax = 64'sd1099511627775;
  localparam longint SumMin = -64'sd1099511627776;

  logic signed [VALUE_W-1:0] coeffs [MAX_TAPS_DEF];
  logic signed [VALUE_W-1:0] row_window [MAX_TAPS_DEF];
  int unsigned               row_len = 0;
  logic [CFG_DATA_W-1:0]     tap_count = CFG_DATA_W'(1);
  logic                      clamp_neg = 1'b0;
  out_item_t                 sums_due [$];
  int                        fail_total = 0;

  initial begin
    fails_o = 0;
    pending_o = 0;
  end

  task automatic filter_request(input in_item_t rq);
    longint      acc;
    int unsigned taps;
    int unsigned i;
    out_item_t   sum;
    if (rq.operation == OP_LOAD_TAP) begin
      if (rq.tap_index < MAX_TAPS_DEF) begin
        coeffs[rq.tap_index] = rq.value;
      end
      return;
    end
    if (rq.row_start) begin
      row_len = 0;
      for (i = 0; i < MAX_TAPS_DEF; i++) begin
        row_window[i] = '0;
      end
    end
    if (row_len >= ROW_MAX_DEF) begin
      return;
    end
    for (i = MAX_TAPS_DEF - 1; i > 0; i--) begin
      row_window[i] = row_window[i-1];
    end
    row_window[0] = rq.value;
    row_len++;
    taps = (tap_count == 0) ? 1 : (tap_count > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_count;
    if (row_len < taps) begin
      return;
    end
    acc = 0;
    for (i = 0; i < taps; i++) begin
      acc += longint'(coeffs[i]) * longint'(row_window[taps-1-i]);
    end
    if (acc > SumMax) begin
      acc = SumMax;
    end
    if (acc < SumMin) begin
      acc = SumMin;
    end
    if (clamp_neg && acc < 0) begin
      acc = 0;
    end
    sum.result   = acc[RESULT_W-1:0];
    sum.position = POSITION_W'(row_len - taps);
    sums_due.push_back(sum);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (sums_due.size() == 0) begin
      $display("%0t: result with none expected: expected nothing, got %0d at position %0d",
               $time, got.result, got.position);
      fail_total++;
      return;
    end
    want = sums_due.pop_front();
    if (got.result !== want.result) begin
      $display("%0t: result mismatch: expected %0d, got %0d", $time, want.result, got.result);
      fail_total++;
    end
    if (got.position !== want.position) begin
      $display("%0t: position mismatch: expected %0d, got %0d",
               $time, want.position, got.position);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len = 0;
      tap_count = CFG_DATA_W'(1);
      clamp_neg = 1'b0;
      foreach (row_window[i]) begin
        row_window[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TAP_COUNT: tap_count = cfg_data_i;
          CFG_ZERO_NEG:  clamp_neg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        filter_request(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_item_i);
      end
    end
    fails_o <= fail_total;
    pending_o <= sums_due.size();
  end

endmodule

// ===== test/tb_fir_row_filter_with_rectify_top.sv =====
// Testbench top for the FIR row filter: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on frf_pkg, fir_row_filter_check and the RTL.
`timescale 1ns / 1ps

module tb_fir_row_filter_with_rectify_top import frf_pkg::*;;

  localparam int unsigned DrainCycles = 2 * MAX_TAPS_DEF + 64;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned IdleLimit   = 20000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_style_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     results_due;

  int unsigned  hold_reqs = 0;
  int unsigned  holds_done = 0;
  int unsigned  hold_count = 0;
  int unsigned  span_left = 0;
  stall_style_e stall_style = STALL_NONE;
  int unsigned  idle_cycles = 0;
  bit           gaps_on = 1'b1;
  int unsigned  burst_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fir_row_filter_with_rectify_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fir_row_filter_check row_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fails_o     (mismatches),
    .pending_o   (results_due)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (holds_done != hold_reqs) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count == LongHold) begin
        hold_count = 0;
        holds_done++;
      end
    end else begin
      if (span_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        span_left = $urandom_range(20, 200);
      end
      span_left--;
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_fir_row_filter_with_rectify_top: errors");
        $finish;
      end
    end
  end

  function automatic int unsigned next_gap();
    if (!gaps_on) begin
      return 0;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      return $urandom_range(1, 8);
    end
    burst_left--;
    return 0;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sample_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic push(input op_e op, input logic [TAP_INDEX_W-1:0] idx,
                      input logic signed [VALUE_W-1:0] val, input logic rs);
    in_item_t    rq;
    int unsigned gap;
    rq.operation = op;
    rq.tap_index = idx;
    rq.value     = val;
    rq.row_start = rs;
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= rq;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic load_tap(input logic [TAP_INDEX_W-1:0] idx,
                          input logic signed [VALUE_W-1:0] val);
    push(OP_LOAD_TAP, idx, val, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_sample(input logic signed [VALUE_W-1:0] val, input logic rs);
    push(OP_PUSH_SAMPLE, TAP_INDEX_W'($urandom), val, rs);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_filter(input logic [CFG_DATA_W-1:0] taps, input logic clamp);
    logic [CFG_DATA_W-1:0] data;
    settle();
    data = CFG_DATA_W'($urandom);
    data[0] = clamp;
    write_reg(CFG_TAP_COUNT, taps);
    write_reg(CFG_ZERO_NEG, data);
  endtask

  task automatic fill_row(input int unsigned len, input logic signed [VALUE_W-1:0] val);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      push_sample(val, k == 0);
    end
  endtask

  task automatic random_phase(input int unsigned items, input bit hold);
    int unsigned           sent;
    int unsigned           row_span;
    int unsigned           taps;
    int unsigned           k;
    logic [CFG_DATA_W-1:0] tc;
    sent = 0;
    tc = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(9, 40))
                                     : CFG_DATA_W'($urandom_range(0, 8));
    set_filter(tc, 1'($urandom_range(0, 1)));
    gaps_on = ($urandom_range(0, 3) != 0);
    taps = (tc == 0) ? 1 : tc;
    if (hold) begin
      hold_reqs <= hold_reqs + 1;
    end
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        row_span = $urandom_range(1, taps);
      end else begin
        row_span = taps + $urandom_range(0, 24);
      end
      for (k = 0; k < row_span && sent < items; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          load_tap(TAP_INDEX_W'($urandom_range(0, 511)), sample_value());
          sent++;
        end
        push_sample(sample_value(), (k == 0) && ($urandom_range(0, 15) != 0));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push(OP_LOAD_TAP, '0, 16'sh7fff, 1'b1);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push(OP_LOAD_TAP, '0, 16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push(OP_LOAD_TAP, 9'h1ff, -16'sd1, 1'b1);
    push(OP_LOAD_TAP, 9'h1ff, 16'sh5555, 1'b0);
    push_sample(16'sd1, 1'b1);
    set_filter(10'd0, 1'b1);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    set_filter(10'd2, 1'b0);
    push(OP_LOAD_TAP, 9'd1, 16'sh7fff, 1'b0);
    push_sample(16'sd100, 1'b1);
    push_sample(-16'sd200, 1'b0);
    push_sample(16'sh2aaa, 1'b0);

    for (i = 0; i < MAX_TAPS_DEF; i++) begin
      load_tap(TAP_INDEX_W'(i), 16'sh8000);
    end
    set_filter(10'd1023, 1'b0);
    fill_row(MAX_TAPS_DEF + 1, 16'sh8000);
    fill_row(MAX_TAPS_DEF + 1, 16'sh7fff);
    set_filter(10'd512, 1'b1);
    fill_row(MAX_TAPS_DEF + 1, 16'sh7fff);

    for (i = 0; i <= 40; i++) begin
      load_tap(TAP_INDEX_W'(i), sample_value());
    end
    set_filter(10'd1, 1'($urandom_range(0, 1)));
    for (i = 0; i < ROW_MAX_DEF + 4; i++) begin
      push_sample(sample_value(), i == 0);
    end
    push_sample(sample_value(), 1'b1);

    for (i = 0; i < 10; i++) begin
      random_phase(125, i == 2);
    end
    settle();

    if (mismatches == 0) begin
      $display("tb_fir_row_filter_with_rectify_top: clean");
    end else begin
      $display("tb_fir_row_filter_with_rectify_top: errors");
    end
    $finish;
  end

endmodule
